>>> hdl/bgic_pkg.sv
// bgic_pkg: shared widths, codes, command and status types for the block grid centroid
// used by every module under block_grid_intensity_centroid, depends on nothing
package bgic_pkg;

	localparam int unsigned PIX_W     = 8;
	localparam int unsigned DIM_W     = 11;
	localparam int unsigned CNT_W     = 10;
	localparam int unsigned GRID_W    = 5;
	localparam int unsigned ACC_W     = 28;
	localparam int unsigned MOM_W     = 38;
	localparam int unsigned AREA_W    = 21;
	localparam int unsigned MEAN_W    = 16;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned IDX_W     = 2;
	localparam int unsigned DIV_CNT_W = $clog2(MOM_W);

	localparam logic [DIM_W-1:0]  MAX_DIM  = 11'd1024;
	localparam logic [GRID_W-1:0] MAX_GRID = 5'd16;

	localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd64;
	localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd64;
	localparam logic [GRID_W-1:0] COLS_RST   = 5'd10;
	localparam logic [GRID_W-1:0] ROWS_RST   = 5'd6;

	localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_SIZE   = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_WEIGHT = 2'd2;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_COLS,
		REG_ROWS
	} reg_idx_t;

	typedef enum logic [2:0] {
		DIV_BW,
		DIV_BH,
		DIV_COL,
		DIV_ROW,
		DIV_MEAN,
		DIV_CX,
		DIV_CY
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_BW,
		ST_BW_WAIT,
		ST_BH,
		ST_BH_WAIT,
		ST_FIX,
		ST_COL,
		ST_COL_WAIT,
		ST_ROW,
		ST_ROW_WAIT,
		ST_RUN,
		ST_MEAN,
		ST_MEAN_WAIT,
		ST_CX,
		ST_CX_WAIT,
		ST_CY,
		ST_CY_WAIT,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic     pixel_we;
		logic     cfg_we;
		logic     div_start;
		div_sel_t div_sel;
		logic     geom_fix;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_busy;
		logic last_pixel;
	} sts_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > MAX_DIM) begin
			r = MAX_DIM;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [GRID_W-1:0] eff_grid(input logic [GRID_W-1:0] v);
		return (v > MAX_GRID) ? MAX_GRID : v;
	endfunction

endpackage

>>> hdl/bgic_div.sv
// bgic_div: shared restoring divider, one quotient bit per cycle
// depends on bgic_pkg for widths
module bgic_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bgic_pkg::MOM_W-1:0]   dividend,
	input  logic [bgic_pkg::ACC_W-1:0]   divisor,
	output logic                         busy,
	output logic                         done,
	output logic [bgic_pkg::MOM_W-1:0]   quotient,
	output logic [bgic_pkg::ACC_W-1:0]   remainder
);

	logic [bgic_pkg::MOM_W-1:0]     dvd_q;
	logic [bgic_pkg::ACC_W-1:0]     dsr_q;
	logic [bgic_pkg::ACC_W-1:0]     rem_q;
	logic [bgic_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [bgic_pkg::ACC_W:0]       trial;
	logic                           ge;
	logic [bgic_pkg::ACC_W:0]       diff;
	logic [bgic_pkg::ACC_W-1:0]     rem_nxt;

	always_comb begin
		trial   = {rem_q, dvd_q[bgic_pkg::MOM_W-1]};
		ge      = trial >= {1'b0, dsr_q};
		diff    = trial - {1'b0, dsr_q};
		rem_nxt = ge ? diff[bgic_pkg::ACC_W-1:0] : trial[bgic_pkg::ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + bgic_pkg::DIV_CNT_W'(1);
				if (cnt_q == bgic_pkg::DIV_CNT_W'(bgic_pkg::MOM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[bgic_pkg::MOM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

>>> hdl/bgic_datapath.sv
// bgic_datapath: config registers, grid geometry, raster counters, moment accumulators
// and result registers; depends on bgic_pkg and bgic_div
module bgic_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bgic_pkg::cmd_t                cmd,
	output bgic_pkg::sts_t                sts,
	input  logic [bgic_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bgic_pkg::DIM_W-1:0]    cfg_data,
	input  logic [bgic_pkg::PIX_W-1:0]    pixel_value,
	output logic [bgic_pkg::CNT_W-1:0]    centroid_x,
	output logic [bgic_pkg::CNT_W-1:0]    centroid_y,
	output logic [bgic_pkg::MEAN_W-1:0]   mean_level,
	output logic [bgic_pkg::STAT_W-1:0]   status
);

	localparam int unsigned DW = bgic_pkg::DIM_W;
	localparam int unsigned CW = bgic_pkg::CNT_W;
	localparam int unsigned GW = bgic_pkg::GRID_W;
	localparam int unsigned PW = bgic_pkg::PIX_W;
	localparam int unsigned AW = bgic_pkg::ACC_W;
	localparam int unsigned MW = bgic_pkg::MOM_W;
	localparam int unsigned PRW = PW + CW;
	localparam int unsigned SPW = GW + DW;
	localparam int unsigned ARW = bgic_pkg::AREA_W;
	localparam int unsigned MNW = bgic_pkg::MEAN_W;

	// configuration
	logic [DW-1:0] width_q, height_q;
	logic [GW-1:0] cols_q, rows_q;
	logic [DW-1:0] w_eff, h_eff;
	logic [GW-1:0] c_eff, r_eff;

	// geometry
	logic [DW-1:0]  bw_q, bh_q;
	logic [CW-1:0]  half_x_q, half_y_q, last_x_q, last_y_q;
	logic [ARW-1:0] area_q;

	// raster position
	logic [CW-1:0] pcol_q, prow_q, bcol_q, brow_q, cin_q, rin_q;
	logic [DW-1:0] basex_q, basey_q;

	// accumulators
	logic [AW-1:0] total_q, covered_q;
	logic [MW-1:0] mx_q, my_q;

	// division results
	logic [MNW-1:0] mean_res_q;
	logic [CW-1:0]  cx_res_q, cy_res_q;

	// output beat
	logic [CW-1:0]               cx_out_q, cy_out_q;
	logic [MNW-1:0]              mean_out_q;
	logic [bgic_pkg::STAT_W-1:0] status_out_q;

	logic           size_ok, covered, last_col_blk, last_row_blk;
	logic [DW-1:0]  ctr_sum_x, ctr_sum_y;
	logic [CW-1:0]  center_x, center_y;
	logic [PRW-1:0] prod_x, prod_y;
	logic           col_end, row_end, cin_wrap, rin_wrap;
	logic [SPW-1:0] span_x, span_y;
	logic [DW-1:0]  rest_x, rest_y;
	logic [ARW-1:0] area_nxt;

	logic                 div_busy, div_done;
	logic [MW-1:0]        div_dvd, div_quo;
	logic [AW-1:0]        div_dsr, div_rem;
	logic [bgic_pkg::STAT_W-1:0] status_nxt;

	assign w_eff = bgic_pkg::eff_dim(width_q);
	assign h_eff = bgic_pkg::eff_dim(height_q);
	assign c_eff = bgic_pkg::eff_grid(cols_q);
	assign r_eff = bgic_pkg::eff_grid(rows_q);

	always_comb begin
		size_ok      = (bw_q != '0) && (bh_q != '0);
		covered      = size_ok && (bcol_q < CW'(c_eff)) && (brow_q < CW'(r_eff));
		last_col_blk = bcol_q == (CW'(c_eff) - CW'(1));
		last_row_blk = brow_q == (CW'(r_eff) - CW'(1));
		ctr_sum_x    = basex_q + DW'(last_col_blk ? last_x_q : half_x_q);
		ctr_sum_y    = basey_q + DW'(last_row_blk ? last_y_q : half_y_q);
		center_x     = ctr_sum_x[CW-1:0];
		center_y     = ctr_sum_y[CW-1:0];
		prod_x       = PRW'(pixel_value) * PRW'(center_x);
		prod_y       = PRW'(pixel_value) * PRW'(center_y);
		col_end      = (DW'(pcol_q) + DW'(1)) >= w_eff;
		row_end      = (DW'(prow_q) + DW'(1)) >= h_eff;
		cin_wrap     = (DW'(cin_q) + DW'(1)) == bw_q;
		rin_wrap     = (DW'(rin_q) + DW'(1)) == bh_q;
		span_x       = SPW'(c_eff - GW'(1)) * SPW'(bw_q);
		span_y       = SPW'(r_eff - GW'(1)) * SPW'(bh_q);
		rest_x       = w_eff - span_x[DW-1:0];
		rest_y       = h_eff - span_y[DW-1:0];
		area_nxt     = ARW'(w_eff) * ARW'(h_eff);
	end

	always_comb begin
		case (cmd.div_sel)
			bgic_pkg::DIV_BW: begin
				div_dvd = MW'(w_eff);
				div_dsr = AW'(c_eff);
			end
			bgic_pkg::DIV_BH: begin
				div_dvd = MW'(h_eff);
				div_dsr = AW'(r_eff);
			end
			bgic_pkg::DIV_COL: begin
				div_dvd = MW'(pcol_q);
				div_dsr = AW'(bw_q);
			end
			bgic_pkg::DIV_ROW: begin
				div_dvd = MW'(prow_q);
				div_dsr = AW'(bh_q);
			end
			bgic_pkg::DIV_MEAN: begin
				div_dvd = {2'b00, total_q, 8'h00};
				div_dsr = AW'(area_q);
			end
			bgic_pkg::DIV_CX: begin
				div_dvd = mx_q;
				div_dsr = covered_q;
			end
			bgic_pkg::DIV_CY: begin
				div_dvd = my_q;
				div_dsr = covered_q;
			end
			default: begin
				div_dvd = '0;
				div_dsr = '0;
			end
		endcase
	end

	bgic_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bgic_pkg::WIDTH_RST;
			height_q <= bgic_pkg::HEIGHT_RST;
			cols_q   <= bgic_pkg::COLS_RST;
			rows_q   <= bgic_pkg::ROWS_RST;
		end else if (cmd.cfg_we) begin
			unique case (bgic_pkg::reg_idx_t'(cfg_index))
				bgic_pkg::REG_WIDTH:  width_q  <= cfg_data;
				bgic_pkg::REG_HEIGHT: height_q <= cfg_data;
				bgic_pkg::REG_COLS:   cols_q   <= cfg_data[GW-1:0];
				bgic_pkg::REG_ROWS:   rows_q   <= cfg_data[GW-1:0];
			endcase
		end
	end

	// geometry and division results
	always_ff @(posedge clk) begin
		if (cmd.geom_fix) begin
			half_x_q <= bw_q[DW-1:1];
			half_y_q <= bh_q[DW-1:1];
			last_x_q <= rest_x[DW-1:1];
			last_y_q <= rest_y[DW-1:1];
			area_q   <= area_nxt;
		end
		if (div_done) begin
			case (cmd.div_sel)
				bgic_pkg::DIV_BW:   bw_q <= (c_eff == '0) ? '0 : div_quo[DW-1:0];
				bgic_pkg::DIV_BH:   bh_q <= (r_eff == '0) ? '0 : div_quo[DW-1:0];
				bgic_pkg::DIV_MEAN: begin
					mean_res_q <= (|div_quo[MW-1:MNW]) ? '1 : div_quo[MNW-1:0];
				end
				bgic_pkg::DIV_CX:   cx_res_q <= div_quo[CW-1:0];
				bgic_pkg::DIV_CY:   cy_res_q <= div_quo[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q  <= '0;
			prow_q  <= '0;
			bcol_q  <= '0;
			brow_q  <= '0;
			cin_q   <= '0;
			rin_q   <= '0;
			basex_q <= '0;
			basey_q <= '0;
		end else if (div_done && (cmd.div_sel == bgic_pkg::DIV_COL)) begin
			bcol_q  <= div_quo[CW-1:0];
			cin_q   <= div_rem[CW-1:0];
			basex_q <= DW'(pcol_q) - DW'(div_rem[CW-1:0]);
		end else if (div_done && (cmd.div_sel == bgic_pkg::DIV_ROW)) begin
			brow_q  <= div_quo[CW-1:0];
			rin_q   <= div_rem[CW-1:0];
			basey_q <= DW'(prow_q) - DW'(div_rem[CW-1:0]);
		end else if (cmd.pixel_we) begin
			if (col_end) begin
				pcol_q  <= '0;
				bcol_q  <= '0;
				cin_q   <= '0;
				basex_q <= '0;
				if (row_end) begin
					prow_q  <= '0;
					brow_q  <= '0;
					rin_q   <= '0;
					basey_q <= '0;
				end else begin
					prow_q <= prow_q + CW'(1);
					if (rin_wrap) begin
						rin_q   <= '0;
						brow_q  <= brow_q + CW'(1);
						basey_q <= basey_q + bh_q;
					end else begin
						rin_q <= rin_q + CW'(1);
					end
				end
			end else begin
				pcol_q <= pcol_q + CW'(1);
				if (cin_wrap) begin
					cin_q   <= '0;
					bcol_q  <= bcol_q + CW'(1);
					basex_q <= basex_q + bw_q;
				end else begin
					cin_q <= cin_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			covered_q <= '0;
			mx_q      <= '0;
			my_q      <= '0;
		end else if (cmd.load_out) begin
			total_q   <= '0;
			covered_q <= '0;
			mx_q      <= '0;
			my_q      <= '0;
		end else if (cmd.pixel_we) begin
			total_q <= total_q + AW'(pixel_value);
			if (covered) begin
				covered_q <= covered_q + AW'(pixel_value);
				mx_q      <= mx_q + MW'(prod_x);
				my_q      <= my_q + MW'(prod_y);
			end
		end
	end

	always_comb begin
		if (!size_ok) begin
			status_nxt = bgic_pkg::STATUS_SIZE;
		end else if (covered_q == '0) begin
			status_nxt = bgic_pkg::STATUS_WEIGHT;
		end else begin
			status_nxt = bgic_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_out_q <= status_nxt;
			mean_out_q   <= mean_res_q;
			cx_out_q     <= (status_nxt == bgic_pkg::STATUS_OK) ? cx_res_q : '0;
			cy_out_q     <= (status_nxt == bgic_pkg::STATUS_OK) ? cy_res_q : '0;
		end
	end

	assign sts.div_done   = div_done;
	assign sts.div_busy   = div_busy;
	assign sts.last_pixel = col_end && row_end;

	assign centroid_x = cx_out_q;
	assign centroid_y = cy_out_q;
	assign mean_level = mean_out_q;
	assign status     = status_out_q;

endmodule

>>> hdl/bgic_ctrl.sv
// bgic_ctrl: sequencer for geometry set-up, pixel intake, end-of-image divisions and output beat
// depends on bgic_pkg
module bgic_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output bgic_pkg::cmd_t cmd,
	input  bgic_pkg::sts_t sts
);

	bgic_pkg::state_t state_q, state_nxt;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bgic_pkg::ST_BW:        state_nxt = bgic_pkg::ST_BW_WAIT;
			bgic_pkg::ST_BW_WAIT:   if (sts.div_done) state_nxt = bgic_pkg::ST_BH;
			bgic_pkg::ST_BH:        state_nxt = bgic_pkg::ST_BH_WAIT;
			bgic_pkg::ST_BH_WAIT:   if (sts.div_done) state_nxt = bgic_pkg::ST_FIX;
			bgic_pkg::ST_FIX:       state_nxt = bgic_pkg::ST_COL;
			bgic_pkg::ST_COL:       state_nxt = bgic_pkg::ST_COL_WAIT;
			bgic_pkg::ST_COL_WAIT:  if (sts.div_done) state_nxt = bgic_pkg::ST_ROW;
			bgic_pkg::ST_ROW:       state_nxt = bgic_pkg::ST_ROW_WAIT;
			bgic_pkg::ST_ROW_WAIT:  if (sts.div_done) state_nxt = bgic_pkg::ST_RUN;
			bgic_pkg::ST_RUN: begin
				if (cfg_valid) begin
					state_nxt = bgic_pkg::ST_BW;
				end else if (in_valid && sts.last_pixel) begin
					state_nxt = bgic_pkg::ST_MEAN;
				end
			end
			bgic_pkg::ST_MEAN:      state_nxt = bgic_pkg::ST_MEAN_WAIT;
			bgic_pkg::ST_MEAN_WAIT: if (sts.div_done) state_nxt = bgic_pkg::ST_CX;
			bgic_pkg::ST_CX:        state_nxt = bgic_pkg::ST_CX_WAIT;
			bgic_pkg::ST_CX_WAIT:   if (sts.div_done) state_nxt = bgic_pkg::ST_CY;
			bgic_pkg::ST_CY:        state_nxt = bgic_pkg::ST_CY_WAIT;
			bgic_pkg::ST_CY_WAIT:   if (sts.div_done) state_nxt = bgic_pkg::ST_LOAD;
			bgic_pkg::ST_LOAD:      if (out_free) state_nxt = bgic_pkg::ST_RUN;
			default:                state_nxt = bgic_pkg::ST_BW;
		endcase
	end

	always_comb begin
		cmd.pixel_we  = 1'b0;
		cmd.cfg_we    = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_sel   = bgic_pkg::DIV_BW;
		cmd.geom_fix  = 1'b0;
		cmd.load_out  = 1'b0;
		in_ready      = 1'b0;
		cfg_ready     = 1'b0;
		unique case (state_q)
			bgic_pkg::ST_BW: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = bgic_pkg::DIV_BW;
			end
			bgic_pkg::ST_BW_WAIT:   cmd.div_sel = bgic_pkg::DIV_BW;
			bgic_pkg::ST_BH: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = bgic_pkg::DIV_BH;
			end
			bgic_pkg::ST_BH_WAIT:   cmd.div_sel = bgic_pkg::DIV_BH;
			bgic_pkg::ST_FIX:       cmd.geom_fix = 1'b1;
			bgic_pkg::ST_COL: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = bgic_pkg::DIV_COL;
			end
			bgic_pkg::ST_COL_WAIT:  cmd.div_sel = bgic_pkg::DIV_COL;
			bgic_pkg::ST_ROW: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = bgic_pkg::DIV_ROW;
			end
			bgic_pkg::ST_ROW_WAIT:  cmd.div_sel = bgic_pkg::DIV_ROW;
			bgic_pkg::ST_RUN: begin
				cfg_ready    = 1'b1;
				in_ready     = !cfg_valid;
				cmd.cfg_we   = cfg_valid;
				cmd.pixel_we = in_valid && !cfg_valid;
			end
			bgic_pkg::ST_MEAN: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = bgic_pkg::DIV_MEAN;
			end
			bgic_pkg::ST_MEAN_WAIT: cmd.div_sel = bgic_pkg::DIV_MEAN;
			bgic_pkg::ST_CX: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = bgic_pkg::DIV_CX;
			end
			bgic_pkg::ST_CX_WAIT:   cmd.div_sel = bgic_pkg::DIV_CX;
			bgic_pkg::ST_CY: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = bgic_pkg::DIV_CY;
			end
			bgic_pkg::ST_CY_WAIT:   cmd.div_sel = bgic_pkg::DIV_CY;
			bgic_pkg::ST_LOAD:      cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bgic_pkg::ST_BW;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_run_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bgic_pkg::ST_RUN) |-> !sts.div_busy)
		else $error("divider busy while taking pixels");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == bgic_pkg::ST_BW_WAIT || state_q == bgic_pkg::ST_BH_WAIT ||
			state_q == bgic_pkg::ST_COL_WAIT || state_q == bgic_pkg::ST_ROW_WAIT ||
			state_q == bgic_pkg::ST_MEAN_WAIT || state_q == bgic_pkg::ST_CX_WAIT ||
			state_q == bgic_pkg::ST_CY_WAIT))
		else $error("divider finished outside a wait state");

	a_last_starts_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pixel_we && sts.last_pixel) |=> (state_q == bgic_pkg::ST_MEAN))
		else $error("last pixel did not start the image result");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.load_out)
		else $error("result overwritten before it was taken");

endmodule

>>> hdl/block_grid_intensity_centroid.sv
// block_grid_intensity_centroid: top level of the block grid intensity centroid
// depends on bgic_pkg, bgic_ctrl, bgic_datapath (with bgic_div)
//
//  channel  signals                                         dir  beat
//  cfg      cfg_valid cfg_ready cfg_index cfg_data          in   one register write
//  in       in_valid in_ready pixel_value                   in   one pixel, raster order
//  out      out_valid out_ready centroid_x centroid_y       out  one result per image
//           mean_level status
//
// one pixel per cycle while an image is streaming and no register write is pending
// last pixel of an image: three 38-step divisions, then the output load
// register write: block size and position set-up on the shared divider
// after reset the same set-up runs before the first pixel is taken
// a waiting result holds the next image's end until taken; pixels keep flowing till then
module block_grid_intensity_centroid (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bgic_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bgic_pkg::DIM_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bgic_pkg::PIX_W-1:0]     pixel_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bgic_pkg::CNT_W-1:0]     centroid_x,
	output logic [bgic_pkg::CNT_W-1:0]     centroid_y,
	output logic [bgic_pkg::MEAN_W-1:0]    mean_level,
	output logic [bgic_pkg::STAT_W-1:0]    status
);

	bgic_pkg::cmd_t cmd;
	bgic_pkg::sts_t sts;

	bgic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bgic_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_value (pixel_value),
		.centroid_x  (centroid_x),
		.centroid_y  (centroid_y),
		.mean_level  (mean_level),
		.status      (status)
	);

endmodule
